// ===== rtl/aip_pkg.sv =====
// Package for the ASCII integer parser: parse phases, radix codes, character codes.
// Used by ascii_integer_parser_radix_prefix; depends on nothing.
`default_nettype none
package aip_pkg;

  typedef enum logic [2:0] {
    PH_SKIP   = 3'd0,
    PH_PREFIX = 3'd1,
    PH_ZERO   = 3'd2,
    PH_DIGITS = 3'd3,
    PH_STOP   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    RX_DEC = 2'd0,
    RX_HEX = 2'd1,
    RX_OCT = 2'd2,
    RX_BIN = 2'd3
  } radix_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } digit_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;

endpackage
`default_nettype wire

// ===== rtl/ascii_integer_parser_radix_prefix.sv =====
// The result beat becomes valid in the cycle after the terminator beat is accepted.
// Throughput: one character per cycle; characters other than the terminator are taken
// even while a result waits, a terminator waits only for a free result register.
// The per-character step is one shift-add of the accumulator by the radix.
// Reset: synchronous, active low; returns to skipping spaces with a zero accumulator.
// Depends on aip_pkg.
`default_nettype none
module ascii_integer_parser_radix_prefix (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [7:0]           in_char_code,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [31:0]        out_parsed_value
);

  aip_pkg::phase_t   phase_r, phase_nxt;
  aip_pkg::radix_t   radix_r, radix_nxt;
  logic              neg_r, neg_nxt;
  logic [31:0]       acc_r, acc_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       out_data_r;

  logic              in_fire, is_term;
  aip_pkg::radix_t   dig_radix;
  logic              do_digit;
  aip_pkg::digit_t   dig;
  logic [31:0]       acc_scaled;

  function automatic aip_pkg::digit_t digit_of(input logic [7:0] c, input aip_pkg::radix_t rx);
    aip_pkg::digit_t d;
    d.ok  = 1'b0;
    d.val = 4'd0;
    unique case (rx)
      aip_pkg::RX_HEX: begin
        if (c >= aip_pkg::CH_UA && c <= aip_pkg::CH_UF) begin
          d.ok  = 1'b1;
          d.val = 4'(c - aip_pkg::CH_UA + 8'd10);
        end else if (c >= aip_pkg::CH_LA && c <= aip_pkg::CH_LF) begin
          d.ok  = 1'b1;
          d.val = 4'(c - aip_pkg::CH_LA + 8'd10);
        end else if (c >= aip_pkg::CH_ZERO && c <= aip_pkg::CH_NINE) begin
          d.ok  = 1'b1;
          d.val = 4'(c - aip_pkg::CH_ZERO);
        end
      end
      aip_pkg::RX_DEC: begin
        if (c >= aip_pkg::CH_ZERO && c <= aip_pkg::CH_NINE) begin
          d.ok  = 1'b1;
          d.val = 4'(c - aip_pkg::CH_ZERO);
        end
      end
      aip_pkg::RX_OCT: begin
        if (c >= aip_pkg::CH_ZERO && c <= aip_pkg::CH_SEVEN) begin
          d.ok  = 1'b1;
          d.val = 4'(c - aip_pkg::CH_ZERO);
        end
      end
      aip_pkg::RX_BIN: begin
        if (c >= aip_pkg::CH_ZERO && c <= aip_pkg::CH_ONE) begin
          d.ok  = 1'b1;
          d.val = 4'(c - aip_pkg::CH_ZERO);
        end
      end
      default: d.ok = 1'b0;
    endcase
    return d;
  endfunction

  assign is_term  = (in_char_code == aip_pkg::CH_NUL);
  // Only a terminator needs room in the result register.
  assign in_ready = !is_term || !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Decide whether this character is treated as a digit, and in which radix.
  always_comb begin
    do_digit  = 1'b0;
    dig_radix = radix_r;
    unique case (phase_r)
      aip_pkg::PH_SKIP, aip_pkg::PH_PREFIX: begin
        if (in_char_code != aip_pkg::CH_ZERO && in_char_code != aip_pkg::CH_B &&
            !(phase_r == aip_pkg::PH_SKIP &&
              (in_char_code == aip_pkg::CH_SPACE || in_char_code == aip_pkg::CH_MINUS))) begin
          do_digit  = 1'b1;
          dig_radix = aip_pkg::RX_DEC;
        end
      end
      aip_pkg::PH_ZERO: begin
        if (in_char_code != aip_pkg::CH_X) begin
          do_digit  = 1'b1;
          dig_radix = aip_pkg::RX_OCT;
        end
      end
      aip_pkg::PH_DIGITS: do_digit = 1'b1;
      default:            do_digit = 1'b0;
    endcase
  end

  assign dig = digit_of(in_char_code, dig_radix);

  always_comb begin
    unique case (dig_radix)
      aip_pkg::RX_HEX: acc_scaled = {acc_r[27:0], 4'd0};
      aip_pkg::RX_OCT: acc_scaled = {acc_r[28:0], 3'd0};
      aip_pkg::RX_BIN: acc_scaled = {acc_r[30:0], 1'b0};
      default:         acc_scaled = {acc_r[28:0], 3'd0} + {acc_r[30:0], 1'b0};
    endcase
  end

  // Next parse state.
  always_comb begin
    phase_nxt = phase_r;
    radix_nxt = radix_r;
    neg_nxt   = neg_r;
    acc_nxt   = acc_r;
    if (in_fire) begin
      if (is_term) begin
        phase_nxt = aip_pkg::PH_SKIP;
        radix_nxt = aip_pkg::RX_DEC;
        neg_nxt   = 1'b0;
        acc_nxt   = '0;
      end else if (do_digit) begin
        radix_nxt = dig_radix;
        if (dig.ok) begin
          acc_nxt   = acc_scaled + {28'd0, dig.val};
          phase_nxt = aip_pkg::PH_DIGITS;
        end else begin
          phase_nxt = aip_pkg::PH_STOP;
        end
      end else begin
        unique case (phase_r)
          aip_pkg::PH_SKIP, aip_pkg::PH_PREFIX: begin
            if (phase_r == aip_pkg::PH_SKIP && in_char_code == aip_pkg::CH_MINUS) begin
              neg_nxt   = 1'b1;
              phase_nxt = aip_pkg::PH_PREFIX;
            end else if (in_char_code == aip_pkg::CH_ZERO) begin
              phase_nxt = aip_pkg::PH_ZERO;
            end else if (in_char_code == aip_pkg::CH_B) begin
              radix_nxt = aip_pkg::RX_BIN;
              phase_nxt = aip_pkg::PH_DIGITS;
            end
            // A leading space leaves everything as it is.
          end
          aip_pkg::PH_ZERO: begin
            radix_nxt = aip_pkg::RX_HEX;
            phase_nxt = aip_pkg::PH_DIGITS;
          end
          default: phase_nxt = aip_pkg::PH_STOP;
        endcase
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (in_fire && is_term) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= aip_pkg::PH_SKIP;
      radix_r     <= aip_pkg::RX_DEC;
      neg_r       <= 1'b0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      radix_r     <= radix_nxt;
      neg_r       <= neg_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && is_term) begin
      out_data_r <= neg_r ? (32'd0 - acc_r) : acc_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_parsed_value = out_data_r;

`ifndef SYNTHESIS
  a_term_resets: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && is_term |=> phase_r == aip_pkg::PH_SKIP && acc_r == 32'd0 && !neg_r)
    else $error("parser state not cleared after terminator");

  a_stop_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !is_term && phase_r == aip_pkg::PH_STOP |=> phase_r == aip_pkg::PH_STOP)
    else $error("parser left the stopped phase before the terminator");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !(in_fire && is_term))
    else $error("terminator accepted while a result was still pending");

  a_char_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !is_term |=> out_valid_r == $past(out_valid_r && !out_ready))
    else $error("result beat appeared without a terminator");
`endif

endmodule
`default_nettype wire

// ===== test/ascii_integer_parser_radix_prefix_tb.sv =====
// Self-checking testbench for the streaming ASCII-to-integer parser with radix prefix.
// A scoreboard class predicts each parsed value from the accepted characters.
// Depends on aip_pkg and ascii_integer_parser_radix_prefix.
`timescale 1ns / 100ps

class atoi_scoreboard;
  aip_pkg::phase_t     phase;
  logic                negative;
  aip_pkg::radix_t     radix;
  logic [31:0]         acc;
  logic signed [31:0]  pending_values[$];
  int                  error_count;
  int                  values_checked;

  function new();
    error_count    = 0;
    values_checked = 0;
    clear_parse();
  endfunction

  function void clear_parse();
    phase    = aip_pkg::PH_SKIP;
    negative = 1'b0;
    radix    = aip_pkg::RX_DEC;
    acc      = '0;
  endfunction

  task report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    error_count++;
  endtask

  // Returns -1 when the character is not a digit of the current radix.
  function int char_digit(logic [7:0] c);
    case (radix)
      aip_pkg::RX_HEX: begin
        if (c >= aip_pkg::CH_UA && c <= aip_pkg::CH_UF)
          return int'(c - aip_pkg::CH_UA) + 10;
        if (c >= aip_pkg::CH_LA && c <= aip_pkg::CH_LF)
          return int'(c - aip_pkg::CH_LA) + 10;
        if (c >= aip_pkg::CH_ZERO && c <= aip_pkg::CH_NINE)
          return int'(c - aip_pkg::CH_ZERO);
      end
      aip_pkg::RX_DEC: begin
        if (c >= aip_pkg::CH_ZERO && c <= aip_pkg::CH_NINE)
          return int'(c - aip_pkg::CH_ZERO);
      end
      aip_pkg::RX_OCT: begin
        if (c >= aip_pkg::CH_ZERO && c <= aip_pkg::CH_SEVEN)
          return int'(c - aip_pkg::CH_ZERO);
      end
      default: begin
        if (c >= aip_pkg::CH_ZERO && c <= aip_pkg::CH_ONE)
          return int'(c - aip_pkg::CH_ZERO);
      end
    endcase
    return -1;
  endfunction

  function logic [31:0] radix_base();
    case (radix)
      aip_pkg::RX_HEX: return 32'd16;
      aip_pkg::RX_OCT: return 32'd8;
      aip_pkg::RX_BIN: return 32'd2;
      default:         return 32'd10;
    endcase
  endfunction

  function void accumulate(logic [7:0] c);
    int d;
    d = char_digit(c);
    if (d < 0) begin
      phase = aip_pkg::PH_STOP;
    end else begin
      acc   = acc * radix_base() + 32'(d);
      phase = aip_pkg::PH_DIGITS;
    end
  endfunction

  // First character after the spaces and the optional sign.
  function void take_first(logic [7:0] c);
    if (c == aip_pkg::CH_ZERO) begin
      phase = aip_pkg::PH_ZERO;
    end else if (c == aip_pkg::CH_B) begin
      radix = aip_pkg::RX_BIN;
      phase = aip_pkg::PH_DIGITS;
    end else begin
      radix = aip_pkg::RX_DEC;
      accumulate(c);
    end
  endfunction

  function void note_char(logic [7:0] c);
    if (c == aip_pkg::CH_NUL) begin
      pending_values.push_back(negative ? -acc : acc);
      clear_parse();
      return;
    end
    case (phase)
      aip_pkg::PH_SKIP: begin
        if (c == aip_pkg::CH_MINUS) begin
          negative = 1'b1;
          phase    = aip_pkg::PH_PREFIX;
        end else if (c != aip_pkg::CH_SPACE) begin
          take_first(c);
        end
      end
      aip_pkg::PH_PREFIX: take_first(c);
      aip_pkg::PH_ZERO: begin
        if (c == aip_pkg::CH_X) begin
          radix = aip_pkg::RX_HEX;
          phase = aip_pkg::PH_DIGITS;
        end else begin
          radix = aip_pkg::RX_OCT;
          accumulate(c);
        end
      end
      aip_pkg::PH_DIGITS: accumulate(c);
      default: phase = aip_pkg::PH_STOP;
    endcase
  endfunction

  task check_value(input logic signed [31:0] got);
    logic signed [31:0] want;
    if (pending_values.size() == 0) begin
      report_mismatch($sformatf("value %0d arrived with none expected", got));
    end else begin
      want = pending_values.pop_front();
      values_checked++;
      if (got !== want)
        report_mismatch($sformatf("value %0d (0x%08h), expected %0d (0x%08h)",
                                  got, got, want, want));
    end
  endtask
endclass

module ascii_integer_parser_radix_prefix_tb;
  localparam int CHAR_TARGET = 1050;
  localparam int CYCLE_LIMIT = 400000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         in_char_code;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_parsed_value;

  atoi_scoreboard sb = new();
  int chars_sent   = 0;
  int strings_sent = 0;
  int burst_left   = 0;

  ascii_integer_parser_radix_prefix dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_char_code     (in_char_code),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_parsed_value (out_parsed_value)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  // Sends one character beat; the sender works in bursts, most of them separated by idle gaps.
  task automatic send_char(input logic [7:0] c);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                               : $urandom_range(1, 30);
    end
    burst_left--;
    @(negedge clk);
    in_valid     <= 1'b1;
    in_char_code <= c;
    do @(posedge clk); while (!in_ready);
    sb.note_char(c);
    chars_sent++;
  endtask

  task automatic send_text(input string t);
    for (int i = 0; i < t.len(); i++) send_char(t[i]);
    send_char(aip_pkg::CH_NUL);
    strings_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_values.size() != 0) @(posedge clk);
  endtask

  // Mostly well-formed numbers with random content; the rest is noise built from
  // random bytes or from the characters that steer the prefix logic.
  task automatic send_random_string();
    int               kind;
    int               n_digits;
    int               v;
    aip_pkg::radix_t  rx;
    logic [7:0]       tricky [8] = '{aip_pkg::CH_SPACE, aip_pkg::CH_MINUS,
                                     aip_pkg::CH_ZERO, aip_pkg::CH_X, aip_pkg::CH_B,
                                     8'h58, aip_pkg::CH_NINE, aip_pkg::CH_UF};
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      repeat ($urandom_range(0, 8)) send_char(8'($urandom_range(1, 255)));
    end else if (kind < 16) begin
      repeat ($urandom_range(1, 6)) send_char(tricky[$urandom_range(0, 7)]);
    end else begin
      repeat ($urandom_range(0, 2)) send_char(aip_pkg::CH_SPACE);
      if ($urandom_range(0, 2) == 0) send_char(aip_pkg::CH_MINUS);
      rx = aip_pkg::radix_t'($urandom_range(0, 3));
      case (rx)
        aip_pkg::RX_HEX: begin
          send_char(aip_pkg::CH_ZERO);
          send_char(aip_pkg::CH_X);
        end
        aip_pkg::RX_OCT: send_char(aip_pkg::CH_ZERO);
        aip_pkg::RX_BIN: send_char(aip_pkg::CH_B);
        default: send_char(aip_pkg::CH_ZERO + 8'($urandom_range(1, 9)));
      endcase
      n_digits = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 8);
      repeat (n_digits) begin
        case (rx)
          aip_pkg::RX_HEX: begin
            v = $urandom_range(0, 15);
            if (v < 10)
              send_char(aip_pkg::CH_ZERO + 8'(v));
            else
              send_char(($urandom_range(0, 1) ? aip_pkg::CH_UA : aip_pkg::CH_LA)
                        + 8'(v - 10));
          end
          aip_pkg::RX_OCT: send_char(aip_pkg::CH_ZERO + 8'($urandom_range(0, 7)));
          aip_pkg::RX_BIN: send_char(aip_pkg::CH_ZERO + 8'($urandom_range(0, 1)));
          default: send_char(aip_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        endcase
      end
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(1, 255)));
    end
    send_char(aip_pkg::CH_NUL);
    strings_sent++;
  endtask

  // The receiver switches between randomly chosen stall patterns.
  initial begin
    int mode;
    int span;
    int tick;
    out_ready = 1'b0;
    tick = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 96);
      repeat (span) begin
        @(negedge clk);
        tick++;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (tick % 5 != 4);
        endcase
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_value(out_parsed_value);
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_char_code = aip_pkg::CH_NUL;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty, all-space, lone zeros, bare prefixes, doubled or spaced sign, mixed-case hex.
    send_text("");
    send_text(" ");
    send_text("0");
    send_text("-0");
    send_text("0x");
    send_text("b");
    send_text("-");
    send_text("--");
    send_text("- ");
    send_text("0xFf");
    send_char(8'hFF);
    send_text("");

    while (chars_sent < CHAR_TARGET) begin
      send_random_string();
      if (strings_sent == 20 || $urandom_range(0, 60) == 0) drain_results();
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (sb.pending_values.size() != 0)
      sb.report_mismatch($sformatf("%0d values never arrived", sb.pending_values.size()));
    $display("Parsed %0d strings from %0d characters in all four radixes,", strings_sent,
             chars_sent);
    $display("with noise and broken prefixes; %0d values compared, %0d mismatches.",
             sb.values_checked, sb.error_count);
    if (sb.error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// ===== ascii_integer_parser_radix_prefix.f =====
rtl/aip_pkg.sv
rtl/ascii_integer_parser_radix_prefix.sv
test/ascii_integer_parser_radix_prefix_tb.sv
